@@ src/fbde_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbde_pkg
// Shared types and codes for the frame buffer draw engine.
// ----------------------------------------------------------------------------
package fbde_pkg;

  // action codes
  localparam logic [2:0] ACT_READ    = 3'd0;
  localparam logic [2:0] ACT_WRITE   = 3'd1;
  localparam logic [2:0] ACT_KEYED   = 3'd2;
  localparam logic [2:0] ACT_OUTLINE = 3'd3;
  localparam logic [2:0] ACT_FILL    = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_KEY_R  = 3'd2;
  localparam logic [2:0] CFG_KEY_G  = 3'd3;
  localparam logic [2:0] CFG_KEY_B  = 3'd4;

  // linear address width: row * width + col with row < 256, width < 512
  localparam int LAW = 18;
  localparam int CW  = 24;

  typedef logic [LAW-1:0] lin_addr_t;
  typedef logic [CW-1:0]  color_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [8:0] width;
    logic [8:0] height;
    color_t     key;
  } cfg_t;

  // classified request as it sits in the queue
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] end_row;
    logic [7:0] end_col;
    color_t     color;
    lin_addr_t  addr;
    logic       in_range;
    logic       key_match;
    logic       empty;
  } cmd_t;

endpackage

@@ src/fbde_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbde request / response interfaces
// Valid/ready channels for draw requests and their results.
// ----------------------------------------------------------------------------
interface fbde_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] row;
  logic [7:0] col;
  logic [7:0] end_row;
  logic [7:0] end_col;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, action, row, col, end_row, end_col, red, green, blue,
                  input ready);
  modport sink (input valid, action, row, col, end_row, end_col, red, green, blue,
                output ready);
endinterface

interface fbde_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       out_of_range;

  modport source (output valid, out_red, out_green, out_blue, out_of_range,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_of_range,
                output ready);
endinterface

@@ src/frame_buffer_draw_engine.sv @@
`timescale 1ns / 1ps
// A write, keyed write, empty rectangle or unknown action loads the result register as the back
// end takes it from the queue; a read first passes S_READ (registered frame memory read).
// A rectangle walks N visited pixels before its result is loaded, clipped ones included:
// (end_row-row+1)*(end_col-col+1) filled, the perimeter pixel count for an outline.
// Throughput: one single-pixel write per cycle while rsp.ready holds; reads and walks block the next.
// Reset clears control state, loads size 256x256 and key zero; frame memory is not cleared.
// ----------------------------------------------------------------------------
// frame_buffer_draw_engine
// RGB frame buffer with pixel read/write, color-keyed write and rectangle
// outline/fill drawing, with clipping to the configured image size.
// ----------------------------------------------------------------------------
module frame_buffer_draw_engine #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic       clk,
  input  logic       rst,
  fbde_req_if.sink   req,
  fbde_rsp_if.source rsp,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic [8:0]     image_width;
  logic [8:0]     image_height;
  logic [7:0]     key_red;
  logic [7:0]     key_green;
  logic [7:0]     key_blue;
  fbde_pkg::cfg_t cfg;

  logic           q_valid;
  fbde_pkg::cmd_t q_cmd;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 9'd256;
      image_height <= 9'd256;
      key_red      <= '0;
      key_green    <= '0;
      key_blue     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fbde_pkg::CFG_WIDTH:  image_width  <= cfg_data;
        fbde_pkg::CFG_HEIGHT: image_height <= cfg_data;
        fbde_pkg::CFG_KEY_R:  key_red      <= cfg_data[7:0];
        fbde_pkg::CFG_KEY_G:  key_green    <= cfg_data[7:0];
        fbde_pkg::CFG_KEY_B:  key_blue     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // clamp sizes to 1..MAX
  always_comb begin
    if (image_width == '0) begin
      cfg.width = 9'd1;
    end else if (int'(image_width) > MAX_COLS) begin
      cfg.width = 9'(MAX_COLS);
    end else begin
      cfg.width = image_width;
    end
    if (image_height == '0) begin
      cfg.height = 9'd1;
    end else if (int'(image_height) > MAX_ROWS) begin
      cfg.height = 9'(MAX_ROWS);
    end else begin
      cfg.height = image_height;
    end
    cfg.key = {key_red, key_green, key_blue};
  end

  fbde_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .req     (req),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  fbde_back #(
    .DEPTH (MAX_ROWS * MAX_COLS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

@@ src/fbde_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbde_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fbde_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/fbde_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbde_front
// Accepts requests, checks bounds and key, computes the start address and
// holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module fbde_front (
  input  logic             clk,
  input  logic             rst,
  input  fbde_pkg::cfg_t   cfg,
  fbde_req_if.sink         req,
  output logic             q_valid,
  output fbde_pkg::cmd_t   q_cmd,
  input  logic             q_pop
);

  fbde_pkg::cmd_t cmd_in;
  fbde_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;

  always_comb begin
    cmd_in.action    = req.action;
    cmd_in.row       = req.row;
    cmd_in.col       = req.col;
    cmd_in.end_row   = req.end_row;
    cmd_in.end_col   = req.end_col;
    cmd_in.color     = {req.red, req.green, req.blue};
    cmd_in.addr      = fbde_pkg::LAW'(fbde_pkg::LAW'(req.row) * fbde_pkg::LAW'(cfg.width))
                       + fbde_pkg::LAW'(req.col);
    cmd_in.in_range  = ({1'b0, req.row} < cfg.height) && ({1'b0, req.col} < cfg.width);
    cmd_in.key_match = ({req.red, req.green, req.blue} == cfg.key);
    cmd_in.empty     = (req.row > req.end_row) || (req.col > req.end_col);
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != 2'd0);
  assign q_cmd     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/fbde_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbde_back
// Executes queued requests against the frame memory: single pixel access,
// or a pixel-per-cycle walk over a rectangle. Owns the result register.
// ----------------------------------------------------------------------------
module fbde_back #(
  parameter int DEPTH = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  fbde_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  fbde_pkg::cmd_t   q_cmd,
  output logic             q_pop,
  fbde_rsp_if.source       rsp
);

  localparam int AW = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WALK} state_t;

  state_t              state;
  logic [7:0]          walk_row;
  logic [7:0]          walk_col;
  logic [7:0]          r0;
  logic [7:0]          c0;
  logic [7:0]          r1;
  logic [7:0]          c1;
  logic                fill;
  logic                flag;
  fbde_pkg::color_t    color;
  fbde_pkg::lin_addr_t cur_addr;
  fbde_pkg::lin_addr_t row_addr;

  logic                out_valid;
  fbde_pkg::color_t    out_color;
  logic                out_flag;

  logic                out_free;
  logic                ram_we;
  fbde_pkg::lin_addr_t ram_waddr;
  fbde_pkg::color_t    ram_wdata;
  logic                ram_re;
  fbde_pkg::color_t    ram_rdata;
  logic                res_load;
  fbde_pkg::color_t    res_color;
  logic                res_flag;
  logic                go_read;
  logic                go_walk;
  logic                pix_in;
  logic                last_col;
  logic                last_row;
  logic                jump;

  assign out_free = !out_valid || rsp.ready;
  assign pix_in   = ({1'b0, walk_row} < cfg.height) && ({1'b0, walk_col} < cfg.width);
  assign last_col = (walk_col == c1);
  assign last_row = (walk_row == r1);
  // outline: inner rows visit only the two side columns
  assign jump     = !fill && (walk_row != r0) && (walk_row != r1) && (walk_col == c0) && !last_col;

  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = q_cmd.addr;
    ram_wdata = q_cmd.color;
    ram_re    = 1'b0;
    res_load  = 1'b0;
    res_color = '0;
    res_flag  = 1'b0;
    go_read   = 1'b0;
    go_walk   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_cmd.action) inside
            fbde_pkg::ACT_READ: begin
              if (q_cmd.in_range) begin
                ram_re  = 1'b1;
                go_read = 1'b1;
              end else begin
                res_load = 1'b1;
                res_flag = 1'b1;
              end
            end
            fbde_pkg::ACT_WRITE: begin
              ram_we   = q_cmd.in_range;
              res_load = 1'b1;
              res_flag = !q_cmd.in_range;
            end
            fbde_pkg::ACT_KEYED: begin
              ram_we   = q_cmd.in_range && !q_cmd.key_match;
              res_load = 1'b1;
              res_flag = !q_cmd.in_range;
            end
            fbde_pkg::ACT_OUTLINE, fbde_pkg::ACT_FILL: begin
              if (q_cmd.empty) begin
                res_load = 1'b1;
              end else begin
                go_walk = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res_load  = 1'b1;
        res_color = ram_rdata;
      end
      S_WALK: begin
        ram_we    = pix_in;
        ram_waddr = cur_addr;
        ram_wdata = color;
        if (!jump && last_col && last_row) begin
          res_load = 1'b1;
          res_flag = flag || !pix_in;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_color <= res_color;
      out_flag  <= res_flag;
    end
    if (go_walk) begin
      r0       <= q_cmd.row;
      c0       <= q_cmd.col;
      r1       <= q_cmd.end_row;
      c1       <= q_cmd.end_col;
      fill     <= (q_cmd.action == fbde_pkg::ACT_FILL);
      color    <= q_cmd.color;
      cur_addr <= q_cmd.addr;
      row_addr <= q_cmd.addr;
    end else if (state == S_WALK) begin
      if (jump) begin
        cur_addr <= cur_addr + fbde_pkg::LAW'(c1 - c0);
      end else if (!last_col) begin
        cur_addr <= cur_addr + fbde_pkg::LAW'(1);
      end else if (!last_row) begin
        row_addr <= row_addr + fbde_pkg::LAW'(cfg.width);
        cur_addr <= row_addr + fbde_pkg::LAW'(cfg.width);
      end
    end
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      walk_row  <= '0;
      walk_col  <= '0;
      flag      <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (go_read) begin
            state <= S_READ;
          end else if (go_walk) begin
            state    <= S_WALK;
            walk_row <= q_cmd.row;
            walk_col <= q_cmd.col;
            flag     <= 1'b0;
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        S_WALK: begin
          flag <= flag || !pix_in;
          if (jump) begin
            walk_col <= c1;
          end else if (!last_col) begin
            walk_col <= walk_col + 8'd1;
          end else if (!last_row) begin
            walk_row <= walk_row + 8'd1;
            walk_col <= c0;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  fbde_ram #(
    .WIDTH (fbde_pkg::CW),
    .DEPTH (DEPTH)
  ) u_frame_memory (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(ram_waddr)),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'(q_cmd.addr)),
    .rdata (ram_rdata)
  );

  assign rsp.valid        = out_valid;
  assign rsp.out_red      = out_color[23:16];
  assign rsp.out_green    = out_color[15:8];
  assign rsp.out_blue     = out_color[7:0];
  assign rsp.out_of_range = out_flag;

endmodule

@@ test/tb_frame_buffer_draw_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_buffer_draw_engine
// Self-checking bench for the frame buffer draw engine. A short scripted
// sequence covers the corners. Random requests then run under a series of
// size and key settings, with random stalls on both channels. A behavioral
// copy of the frame buffer predicts the pixel reads and range flags that the
// script does not give, and the responses are checked in order.
// ----------------------------------------------------------------------------
module tb_frame_buffer_draw_engine;

  localparam int FB_ROWS = 256;
  localparam int FB_COLS = 256;
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT = 20;

  typedef struct packed {
    logic [2:0]       action;
    logic [7:0]       row;
    logic [7:0]       col;
    logic [7:0]       end_row;
    logic [7:0]       end_col;
    fbde_pkg::color_t color;
  } draw_req_t;

  typedef struct packed {
    fbde_pkg::color_t pixel;
    logic             out_of_range;
  } pixel_rsp_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_TYPED} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [2:0] cfg_index;
    logic [8:0] cfg_value;
    draw_req_t  req;
    pixel_rsp_t rsp;
  } script_row_t;

  // first row paints the whole buffer so no later read hits an unwritten pixel
  localparam script_row_t SCRIPT [31] = '{
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 24'h102030}, '{24'h0, 1'b0}},
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0, 24'h0}, '{24'h102030, 1'b0}},
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_WRITE, 8'd255, 8'd255, 8'd0, 8'd0, 24'hFFFFFF}, '{24'h0, 1'b0}},
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_READ, 8'd255, 8'd255, 8'd0, 8'd0, 24'h0}, '{24'hFFFFFF, 1'b0}},
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 24'h000000}, '{24'h0, 1'b0}},
    // key is black after reset: nothing stored
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_KEYED, 8'd1, 8'd1, 8'd0, 8'd0, 24'h000000}, '{24'h0, 1'b0}},
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_READ, 8'd1, 8'd1, 8'd0, 8'd0, 24'h0}, '{24'h102030, 1'b0}},
    '{ROW_PRED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_KEYED, 8'd1, 8'd1, 8'd0, 8'd0, 24'hA55AC3}, '0},
    '{ROW_PRED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_READ, 8'd1, 8'd1, 8'd0, 8'd0, 24'h0}, '0},
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_OUTLINE, 8'd2, 8'd2, 8'd6, 8'd9, 24'h3C3C3C}, '{24'h0, 1'b0}},
    '{ROW_PRED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_READ, 8'd2, 8'd5, 8'd0, 8'd0, 24'h0}, '0},
    '{ROW_PRED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_READ, 8'd4, 8'd5, 8'd0, 8'd0, 24'h0}, '0},
    // start row past end row draws nothing
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_OUTLINE, 8'd9, 8'd0, 8'd3, 8'd5, 24'h777777}, '{24'h0, 1'b0}},
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{ACT_SPARE_HI, 8'd255, 8'd255, 8'd255, 8'd255, 24'hFFFFFF}, '{24'h0, 1'b0}},
    '{ROW_CFG, fbde_pkg::CFG_WIDTH, 9'd10, '0, '0},
    '{ROW_CFG, fbde_pkg::CFG_HEIGHT, 9'd6, '0, '0},
    '{ROW_CFG, fbde_pkg::CFG_KEY_R, 9'h12, '0, '0},
    '{ROW_CFG, fbde_pkg::CFG_KEY_G, 9'h34, '0, '0},
    '{ROW_CFG, fbde_pkg::CFG_KEY_B, 9'h56, '0, '0},
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_WRITE, 8'd6, 8'd0, 8'd0, 8'd0, 24'hABCDEF}, '{24'h0, 1'b1}},
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_READ, 8'd0, 8'd10, 8'd0, 8'd0, 24'h0}, '{24'h0, 1'b1}},
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_KEYED, 8'd5, 8'd10, 8'd0, 8'd0, 24'h123456}, '{24'h0, 1'b1}},
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_KEYED, 8'd5, 8'd9, 8'd0, 8'd0, 24'h123456}, '{24'h0, 1'b0}},
    '{ROW_PRED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_READ, 8'd5, 8'd9, 8'd0, 8'd0, 24'h0}, '0},
    // partly clipped fill
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_FILL, 8'd4, 8'd8, 8'd7, 8'd12, 24'h00FF00}, '{24'h0, 1'b1}},
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_OUTLINE, 8'd200, 8'd200, 8'd201, 8'd201, 24'h0000FF},
      '{24'h0, 1'b1}},
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{ACT_SPARE_LO, 8'd1, 8'd1, 8'd2, 8'd2, 24'h010101}, '{24'h0, 1'b0}},
    // size registers beyond their range clamp to 256 wide, 1 high
    '{ROW_CFG, fbde_pkg::CFG_WIDTH, 9'd511, '0, '0},
    '{ROW_CFG, fbde_pkg::CFG_HEIGHT, 9'd0, '0, '0},
    '{ROW_TYPED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_WRITE, 8'd1, 8'd0, 8'd0, 8'd0, 24'h202020}, '{24'h0, 1'b1}},
    '{ROW_PRED, fbde_pkg::CFG_WIDTH, 9'd0,
      '{fbde_pkg::ACT_READ, 8'd0, 8'd255, 8'd0, 8'd0, 24'h0}, '0}
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [8:0] cfg_data;

  fbde_req_if req_ch ();
  fbde_rsp_if rsp_ch ();

  frame_buffer_draw_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // behavioral frame buffer and register copy
  fbde_pkg::color_t shadow_fb [0:FB_ROWS*FB_COLS-1];
  logic [8:0]       model_width_reg;
  logic [8:0]       model_height_reg;
  fbde_pkg::color_t model_key;
  pixel_rsp_t       pending_q [$];

  // scripted result that travels with the request currently driven
  logic        drv_typed;
  pixel_rsp_t  drv_typed_rsp;

  logic        calm;
  logic [7:0]  recent_row;
  logic [7:0]  recent_col;
  int unsigned fail_count = 0;
  int unsigned accepted_count = 0;
  int unsigned reads_done = 0;
  int unsigned flagged_count = 0;
  int unsigned reg_writes = 0;

  function automatic int unsigned used_width();
    if (model_width_reg == 9'd0) return 1;
    if (model_width_reg > FB_COLS) return FB_COLS;
    return 32'(model_width_reg);
  endfunction

  function automatic int unsigned used_height();
    if (model_height_reg == 9'd0) return 1;
    if (model_height_reg > FB_ROWS) return FB_ROWS;
    return 32'(model_height_reg);
  endfunction

  function automatic bit plot(int unsigned r, int unsigned c, fbde_pkg::color_t color);
    if (r >= used_height() || c >= used_width()) return 1'b0;
    shadow_fb[16'(r * used_width() + c)] = color;
    return 1'b1;
  endfunction

  function automatic pixel_rsp_t apply_request(draw_req_t q);
    pixel_rsp_t res;
    res = '0;
    case (q.action) inside
      fbde_pkg::ACT_READ: begin
        if (32'(q.row) < used_height() && 32'(q.col) < used_width())
          res.pixel = shadow_fb[16'(32'(q.row) * used_width() + 32'(q.col))];
        else
          res.out_of_range = 1'b1;
      end
      fbde_pkg::ACT_WRITE: res.out_of_range = !plot(32'(q.row), 32'(q.col), q.color);
      fbde_pkg::ACT_KEYED: begin
        if (32'(q.row) >= used_height() || 32'(q.col) >= used_width())
          res.out_of_range = 1'b1;
        else if (q.color != model_key)
          void'(plot(32'(q.row), 32'(q.col), q.color));
      end
      fbde_pkg::ACT_OUTLINE, fbde_pkg::ACT_FILL: begin
        if (q.row <= q.end_row && q.col <= q.end_col) begin
          for (int unsigned r = 32'(q.row); r <= 32'(q.end_row); r++) begin
            for (int unsigned c = 32'(q.col); c <= 32'(q.end_col); c++) begin
              if (q.action == fbde_pkg::ACT_FILL || r == 32'(q.row) ||
                  r == 32'(q.end_row) || c == 32'(q.col) || c == 32'(q.end_col)) begin
                if (!plot(r, c, q.color)) res.out_of_range = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic draw_req_t random_request();
    draw_req_t   q;
    int unsigned w, h, pick, shape, end_r, end_c;
    w = used_width();
    h = used_height();
    pick = $urandom_range(99);
    q.color = fbde_pkg::color_t'($urandom());
    q.end_row = 8'($urandom());
    q.end_col = 8'($urandom());
    if (pick < 30) q.action = fbde_pkg::ACT_READ;
    else if (pick < 50) q.action = fbde_pkg::ACT_WRITE;
    else if (pick < 65) q.action = fbde_pkg::ACT_KEYED;
    else if (pick < 79) q.action = fbde_pkg::ACT_OUTLINE;
    else if (pick < 94) q.action = fbde_pkg::ACT_FILL;
    else q.action = 3'($urandom_range(32'(ACT_SPARE_HI), 32'(ACT_SPARE_LO)));

    // mostly inside the image, some on the border or anywhere
    case ($urandom_range(9))
      0, 1: begin
        q.row = 8'($urandom());
        q.col = 8'($urandom());
      end
      2: begin
        q.row = (h < FB_ROWS) ? 8'(h) : 8'(FB_ROWS - 1);
        q.col = 8'($urandom_range(w - 1));
      end
      3: begin
        q.row = 8'($urandom_range(h - 1));
        q.col = (w < FB_COLS) ? 8'(w) : 8'(FB_COLS - 1);
      end
      default: begin
        q.row = 8'($urandom_range(h - 1));
        q.col = 8'($urandom_range(w - 1));
      end
    endcase

    if (q.action == fbde_pkg::ACT_READ && $urandom_range(1) == 1) begin
      q.row = recent_row;
      q.col = recent_col;
    end
    if ((q.action == fbde_pkg::ACT_KEYED || q.action == fbde_pkg::ACT_WRITE) &&
        $urandom_range(3) == 0)
      q.color = model_key;

    if (q.action == fbde_pkg::ACT_OUTLINE || q.action == fbde_pkg::ACT_FILL) begin
      shape = $urandom_range(49);
      if (shape == 0) begin
        end_r = 32'(q.row) + $urandom_range(63);
        end_c = 32'(q.col) + $urandom_range(63);
      end else begin
        end_r = 32'(q.row) + $urandom_range(5);
        end_c = 32'(q.col) + $urandom_range(5);
      end
      // a few empty rectangles
      if (shape >= 1 && shape <= 4) begin
        if (q.row > 0) end_r = $urandom_range(32'(q.row) - 1);
        else if (q.col > 0) end_c = $urandom_range(32'(q.col) - 1);
      end
      q.end_row = (end_r > FB_ROWS - 1) ? 8'(FB_ROWS - 1) : 8'(end_r);
      q.end_col = (end_c > FB_COLS - 1) ? 8'(FB_COLS - 1) : 8'(end_c);
      recent_row = q.end_row;
      recent_col = q.end_col;
    end else if (q.action == fbde_pkg::ACT_WRITE || q.action == fbde_pkg::ACT_KEYED) begin
      recent_row = q.row;
      recent_col = q.col;
    end
    return q;
  endfunction

  // response check first: a response at this edge belongs to an older request
  always @(posedge clk) begin
    draw_req_t  q;
    pixel_rsp_t want;
    pixel_rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.pixel = {rsp_ch.out_red, rsp_ch.out_green, rsp_ch.out_blue};
      got.out_of_range = rsp_ch.out_of_range;
      if (pending_q.size() == 0) begin
        $error("response with no request outstanding");
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (got.pixel[23:16] !== want.pixel[23:16]) begin
          $error("out_red: expected %0h, got %0h", want.pixel[23:16], got.pixel[23:16]);
          fail_count++;
        end
        if (got.pixel[15:8] !== want.pixel[15:8]) begin
          $error("out_green: expected %0h, got %0h", want.pixel[15:8], got.pixel[15:8]);
          fail_count++;
        end
        if (got.pixel[7:0] !== want.pixel[7:0]) begin
          $error("out_blue: expected %0h, got %0h", want.pixel[7:0], got.pixel[7:0]);
          fail_count++;
        end
        if (got.out_of_range !== want.out_of_range) begin
          $error("out_of_range: expected %0b, got %0b", want.out_of_range,
                 got.out_of_range);
          fail_count++;
        end
      end
    end
    if (!rst && req_ch.valid && req_ch.ready) begin
      q.action  = req_ch.action;
      q.row     = req_ch.row;
      q.col     = req_ch.col;
      q.end_row = req_ch.end_row;
      q.end_col = req_ch.end_col;
      q.color   = {req_ch.red, req_ch.green, req_ch.blue};
      want = apply_request(q);
      if (drv_typed) want = drv_typed_rsp;
      pending_q.push_back(want);
      accepted_count++;
      if (q.action == fbde_pkg::ACT_READ && !want.out_of_range) reads_done++;
      if (want.out_of_range) flagged_count++;
    end
  end

  always @(negedge clk) rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(draw_req_t q, logic typed, pixel_rsp_t typed_rsp);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid   = 1'b1;
    req_ch.action  = q.action;
    req_ch.row     = q.row;
    req_ch.col     = q.col;
    req_ch.end_row = q.end_row;
    req_ch.end_col = q.end_col;
    req_ch.red     = q.color[23:16];
    req_ch.green   = q.color[15:8];
    req_ch.blue    = q.color[7:0];
    drv_typed      = typed;
    drv_typed_rsp  = typed_rsp;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_ch.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [8:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      fbde_pkg::CFG_WIDTH:  model_width_reg = value;
      fbde_pkg::CFG_HEIGHT: model_height_reg = value;
      fbde_pkg::CFG_KEY_R:  model_key[23:16] = value[7:0];
      fbde_pkg::CFG_KEY_G:  model_key[15:8] = value[7:0];
      fbde_pkg::CFG_KEY_B:  model_key[7:0] = value[7:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_settings(logic [8:0] w, logic [8:0] h, fbde_pkg::color_t key);
    wait_idle();
    write_register(fbde_pkg::CFG_WIDTH, w);
    write_register(fbde_pkg::CFG_HEIGHT, h);
    write_register(fbde_pkg::CFG_KEY_R, {1'b0, key[23:16]});
    write_register(fbde_pkg::CFG_KEY_G, {1'b0, key[15:8]});
    write_register(fbde_pkg::CFG_KEY_B, {1'b0, key[7:0]});
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = fbde_pkg::CFG_WIDTH;
    cfg_data       = '0;
    req_ch.valid   = 1'b0;
    req_ch.action  = fbde_pkg::ACT_READ;
    req_ch.row     = '0;
    req_ch.col     = '0;
    req_ch.end_row = '0;
    req_ch.end_col = '0;
    req_ch.red     = '0;
    req_ch.green   = '0;
    req_ch.blue    = '0;
    rsp_ch.ready   = 1'b0;
    drv_typed      = 1'b0;
    drv_typed_rsp  = '0;
    calm           = 1'b0;
    recent_row     = '0;
    recent_col     = '0;
    model_width_reg  = 9'd256;
    model_height_reg = 9'd256;
    model_key        = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        wait_idle();
        write_register(SCRIPT[i].cfg_index, SCRIPT[i].cfg_value);
      end else begin
        send_request(SCRIPT[i].req, SCRIPT[i].kind == ROW_TYPED, SCRIPT[i].rsp);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: load_settings(9'd256, 9'd256, '0);
        1: load_settings(9'd1, 9'd256, fbde_pkg::color_t'($urandom()));
        2: load_settings(9'd256, 9'd1, 24'hFFFFFF);
        3: load_settings(9'd0, 9'd511, fbde_pkg::color_t'($urandom()));
        4: load_settings(9'($urandom_range(511, 257)), 9'd0,
                         fbde_pkg::color_t'($urandom()));
        default: load_settings(9'($urandom_range(256, 1)), 9'($urandom_range(256, 1)),
                               fbde_pkg::color_t'($urandom()));
      endcase
      // one phase runs with both channels never idling
      calm = (p == 5);
      repeat (ITEMS_PER_PHASE) send_request(random_request(), 1'b0, '0);
    end
    calm = 1'b0;
    wait_idle();

    $display("Ran %0d requests under %0d register writes, %0d size and key settings",
             accepted_count, reg_writes, RANDOM_PHASES);
    $display("%0d in-image pixel reads, %0d results flagged out of image",
             reads_done, flagged_count);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #36_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ frame_buffer_draw_engine.f @@
src/fbde_pkg.sv
src/fbde_ifs.sv
src/fbde_ram.sv
src/fbde_front.sv
src/fbde_back.sv
src/frame_buffer_draw_engine.sv
test/tb_frame_buffer_draw_engine.sv
